@@ design/lrt_pkg.sv @@
`timescale 1ns / 1ps

package lrt_pkg;

	// Configuration register indexes.
	localparam logic REG_SYMMETRIC_MODE = 1'b0;

	// Width of the APB data bus.
	localparam int APB_DATA_BITS = 32;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // take a new line and emit its first cell
		logic step;    // one full major step, with a minor step if the error overflows
		logic tie;     // major step only, emitting the corner cell of an exact tie
		logic finish;  // minor step that completes a tie step
	} lrt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero_len;  // the incoming line has equal ends
		logic tie;       // the coming step lands exactly on a tie in symmetric mode
		logic last;      // one major step remains
	} lrt_status_t;

endpackage

@@ design/lrt_ctrl.sv @@
`timescale 1ns / 1ps

module lrt_ctrl import lrt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  lrt_status_t status,
	output lrt_cmd_t    cmd,
	output logic        busy
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1;
	localparam logic [1:0] ST_TIE  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;

	assign busy = (state_q != ST_IDLE);

	// Next state and the command for this cycle.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!status.zero_len) begin
						state_next = ST_STEP;
					end
				end
			end
			ST_STEP: begin
				if (status.tie) begin
					cmd.tie    = 1'b1;
					state_next = ST_TIE;
				end else begin
					cmd.step = 1'b1;
					if (status.last) begin
						state_next = ST_IDLE;
					end
				end
			end
			ST_TIE: begin
				cmd.finish = 1'b1;
				state_next = status.last ? ST_IDLE : ST_STEP;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

@@ design/lrt_datapath.sv @@
`timescale 1ns / 1ps

module lrt_datapath import lrt_pkg::*; #(
	parameter int COORD_BITS = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lrt_cmd_t              cmd,
	input  logic                  symmetric_mode,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output lrt_status_t           status,
	output logic                  point_valid,
	output logic [COORD_BITS-1:0] point_x,
	output logic [COORD_BITS-1:0] point_y,
	output logic                  last_point
);

	// The accumulator stays below four times the major distance.
	localparam int ACC_BITS = COORD_BITS + 2;

	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, steps_q;
	logic [ACC_BITS-1:0]   acc_q, two_major_q, two_minor_q;
	logic                  x_major_q, neg_x_q, neg_y_q;

	logic [COORD_BITS-1:0] dx, dy, major, minor;
	logic                  x_major_in;
	logic [COORD_BITS-1:0] inc_x, inc_y;
	logic [ACC_BITS-1:0]   acc_sum;
	logic                  overflow;
	logic [COORD_BITS-1:0] next_x, next_y;
	logic                  emit, emit_last;

	// Distances and major axis of the incoming line.
	always_comb begin
		dx         = (end_x > start_x) ? (end_x - start_x) : (start_x - end_x);
		dy         = (end_y > start_y) ? (end_y - start_y) : (start_y - end_y);
		x_major_in = (dx >= dy);
		major      = x_major_in ? dx : dy;
		minor      = x_major_in ? dy : dx;
	end

	// One step of the cursor along either axis.
	assign inc_x = neg_x_q ? (cur_x_q - 1'b1) : (cur_x_q + 1'b1);
	assign inc_y = neg_y_q ? (cur_y_q - 1'b1) : (cur_y_q + 1'b1);

	// Error update of the coming major step.
	assign acc_sum  = acc_q + two_minor_q;
	assign overflow = (acc_sum >= two_major_q);

	assign status.zero_len = (major == '0);
	assign status.tie      = symmetric_mode && (acc_sum == two_major_q);
	assign status.last     = (steps_q == COORD_BITS'(1));

	// Cell emitted this cycle.
	always_comb begin
		next_x    = cur_x_q;
		next_y    = cur_y_q;
		emit_last = 1'b0;
		if (cmd.load) begin
			next_x    = start_x;
			next_y    = start_y;
			emit_last = status.zero_len;
		end else if (cmd.step) begin
			if (x_major_q) begin
				next_x = inc_x;
				if (overflow) begin
					next_y = inc_y;
				end
			end else begin
				next_y = inc_y;
				if (overflow) begin
					next_x = inc_x;
				end
			end
			emit_last = status.last;
		end else if (cmd.tie) begin
			if (x_major_q) begin
				next_x = inc_x;
			end else begin
				next_y = inc_y;
			end
		end else if (cmd.finish) begin
			if (x_major_q) begin
				next_y = inc_y;
			end else begin
				next_x = inc_x;
			end
			emit_last = status.last;
		end
	end

	assign emit = cmd.load | cmd.step | cmd.tie | cmd.finish;

	// Line registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_major_q   <= x_major_in;
			neg_x_q     <= (end_x < start_x);
			neg_y_q     <= (end_y < start_y);
			acc_q       <= ACC_BITS'(major);
			steps_q     <= major;
			two_major_q <= {1'b0, major, 1'b0};
			two_minor_q <= {1'b0, minor, 1'b0};
		end else if (cmd.step) begin
			acc_q   <= overflow ? (acc_sum - two_major_q) : acc_sum;
			steps_q <= steps_q - 1'b1;
		end else if (cmd.tie) begin
			acc_q <= acc_sum - two_major_q;
		end else if (cmd.finish) begin
			steps_q <= steps_q - 1'b1;
		end
		if (emit) begin
			cur_x_q <= next_x;
			cur_y_q <= next_y;
		end
	end

	// Result register: each cell shows for exactly one cycle.
	logic                  point_valid_q;
	logic [COORD_BITS-1:0] point_x_q, point_y_q;
	logic                  last_point_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid_q <= 1'b0;
		end else begin
			point_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			point_x_q    <= next_x;
			point_y_q    <= next_y;
			last_point_q <= emit_last;
		end
	end

	assign point_valid = point_valid_q;
	assign point_x     = point_x_q;
	assign point_y     = point_y_q;
	assign last_point  = last_point_q;

endmodule

@@ design/line_rasterizer_with_tie_points.sv @@
`timescale 1ns / 1ps

// Bresenham line rasterizer. A transfer is accepted when start is high and busy is low;
// the cells of the line from (start_x, start_y) to (end_x, end_y) then appear one per
// clock on point_x/point_y, each marked by point_valid for a single cycle, beginning
// the cycle after acceptance. The receiver cannot stall the block, so every cell must
// be taken as it is shown. The final cell is the end point and carries last_point.
// With symmetric_mode set, an exact error tie adds a corner cell before the minor step.
// A line yields 1 + M + T cells, where M is the larger of the two coordinate distances
// and T the number of tie cells; the sequencer emits one cell per cycle, and a line with
// equal ends yields only its start cell and leaves busy low.

module line_rasterizer_with_tie_points import lrt_pkg::*; #(
	parameter int COORD_BITS = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [COORD_BITS-1:0]    start_x,
	input  logic [COORD_BITS-1:0]    start_y,
	input  logic [COORD_BITS-1:0]    end_x,
	input  logic [COORD_BITS-1:0]    end_y,
	output logic                     point_valid,
	output logic [COORD_BITS-1:0]    point_x,
	output logic [COORD_BITS-1:0]    point_y,
	output logic                     last_point,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [APB_DATA_BITS-1:0] pwdata,
	output logic [APB_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	lrt_cmd_t    cmd;
	lrt_status_t status;
	logic        symmetric_mode_q;
	logic        reg_hit;

	// Register decode: one register, decoded at byte addresses zero to three (paddr[2] low).
	assign reg_hit = (paddr[2] == REG_SYMMETRIC_MODE);
	assign pready  = 1'b1;
	assign prdata  = reg_hit ? {{(APB_DATA_BITS-1){1'b0}}, symmetric_mode_q} : '0;

	// Configuration write on the access phase of the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symmetric_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			symmetric_mode_q <= pwdata[0];
		end
	end

	lrt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	lrt_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.symmetric_mode (symmetric_mode_q),
		.start_x        (start_x),
		.start_y        (start_y),
		.end_x          (end_x),
		.end_y          (end_y),
		.status         (status),
		.point_valid    (point_valid),
		.point_x        (point_x),
		.point_y        (point_y),
		.last_point     (last_point)
	);

endmodule
